### sv/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

    localparam int WORD_W    = 32;
    localparam int BLK_WORDS = 16;
    localparam int DIG_WORDS = 8;
    localparam int ROUNDS    = 64;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BLK_WORDS-1:0][WORD_W-1:0] block_t;
    // word 0 is H0, the most significant digest word
    typedef logic [0:DIG_WORDS-1][WORD_W-1:0] hash_t;

    // one queued block; last_blk marks the final block of a message
    typedef struct packed {
        block_t blk;
        logic   last_blk;
    } q_entry_t;

    typedef enum logic [1:0] {FR_ACCEPT, FR_MARK, FR_ZERO, FR_LEN} front_state_t;
    typedef enum logic [1:0] {BK_IDLE, BK_ROUND, BK_ADD, BK_EMIT} back_state_t;

    localparam hash_t INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t small_sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        unique case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

### sv/sha_if.sv
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### sv/sha256_message_hasher.sv
`timescale 1ns / 1ps
// Sequence: after the end-of-message request, the front pads (0x80 mark, zero bytes, 8 length
//   bytes); each queued block goes through pop, 64 rounds and hash add, then 8 digest words.
// Throughput: one byte per cycle while the queue has room; each 64-byte block holds the single
//   round unit from pop through hash add, and the next block is popped only after that.
// Reset (rst_n, async, active low): hash returns to the SHA-256 IV, counters and queue clear.
module sha256_message_hasher
    import sha_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    msg,
    sha_out_if.source dig
);

    // front: packs bytes, pads, pushes complete blocks
    // queue: holds blocks so byte intake overlaps compression
    // back: 64-round compression, hash update, digest readout

    logic     q_push, q_full, q_pop, q_valid;
    q_entry_t q_in, q_head;

    sha_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    sha_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    sha_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .dig     (dig)
    );

endmodule

### sv/sha_front.sv
`timescale 1ns / 1ps
module sha_front
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    msg,
    input  logic      q_full,
    output logic      q_push,
    output q_entry_t  q_data
);

    front_state_t st_reg, st_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  len_reg, len_next;
    logic [63:0]  lsh_reg, lsh_next;   // latched length, shifted out MSB first
    logic [2:0]   lidx_reg, lidx_next;
    block_t       blk_reg, blk_next;

    logic         wr_en;
    logic [7:0]   wr_byte;
    logic         wr_last;
    logic         acc;
    word_t        word_v;
    logic [3:0]   slot;
    logic [4:0]   shamt;

    assign acc = msg.valid && msg.ready;

    always_comb
    begin
        st_next   = st_reg;
        len_next  = len_reg;
        lsh_next  = lsh_reg;
        lidx_next = lidx_reg;
        wr_en     = 1'b0;
        wr_byte   = '0;
        wr_last   = 1'b0;
        msg.ready = 1'b0;
        unique case (st_reg)
            FR_ACCEPT:
            begin
                msg.ready = !q_full;
                if (acc)
                begin
                    if (msg.has_byte)
                    begin
                        wr_en    = 1'b1;
                        wr_byte  = msg.data_byte;
                        len_next = len_reg + 64'd8;
                    end
                    if (msg.end_of_message)
                    begin
                        lsh_next = len_reg + (msg.has_byte ? 64'd8 : 64'd0);
                        len_next = '0;
                        st_next  = FR_MARK;
                    end
                end
            end
            FR_MARK:
            begin
                if (!q_full)
                begin
                    wr_en   = 1'b1;
                    wr_byte = PAD_MARK;
                    st_next = FR_ZERO;
                end
            end
            FR_ZERO:
            begin
                if (pos_reg == LEN_POS)
                begin
                    st_next   = FR_LEN;
                    lidx_next = '0;
                end
                else if (!q_full)
                begin
                    wr_en = 1'b1;
                end
            end
            FR_LEN:
            begin
                if (!q_full)
                begin
                    wr_en     = 1'b1;
                    wr_byte   = lsh_reg[63:56];
                    lsh_next  = {lsh_reg[55:0], 8'h00};
                    lidx_next = lidx_reg + 3'd1;
                    if (lidx_reg == 3'd7)
                    begin
                        wr_last = 1'b1;
                        st_next = FR_ACCEPT;
                    end
                end
            end
            default: st_next = FR_ACCEPT;
        endcase
    end

    // big-endian byte packing
    always_comb
    begin
        slot     = pos_reg[5:2];
        shamt    = {~pos_reg[1:0], 3'b000};
        word_v   = (pos_reg[1:0] == 2'd0) ? '0 : blk_reg[slot];
        word_v   = word_v | (word_t'(wr_byte) << shamt);
        blk_next = blk_reg;
        blk_next[slot] = word_v;
        pos_next = wr_en ? pos_reg + 6'd1 : pos_reg;
    end

    assign q_push          = wr_en && (pos_reg == LAST_POS);
    assign q_data.blk      = blk_next;
    assign q_data.last_blk = wr_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= FR_ACCEPT;
            pos_reg  <= '0;
            len_reg  <= '0;
            lidx_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            lidx_reg <= lidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lsh_reg <= lsh_next;
        if (wr_en)
        begin
            blk_reg <= blk_next;
        end
    end

endmodule

### sv/sha_queue.sv
`timescale 1ns / 1ps
module sha_queue
    import sha_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output q_entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        mem [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

### sv/sha_back.sv
`timescale 1ns / 1ps
module sha_back
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  q_entry_t  q_head,
    output logic      q_pop,
    sha_out_if.source dig
);

    back_state_t st_reg, st_next;
    hash_t       hash_reg;
    hash_t       v_reg, v_next;
    block_t      win_reg, win_next;
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        fin_reg;

    word_t w, t1, t2;

    assign q_pop = (st_reg == BK_IDLE) && q_valid;

    // one round per cycle; window shifts so win[0] is W[r] below round 16 and W[r-16] after
    always_comb
    begin
        if (rnd_reg < 6'd16)
        begin
            w = win_reg[0];
        end
        else
        begin
            w = small_sig1(win_reg[14]) + win_reg[9] + small_sig0(win_reg[1]) + win_reg[0];
        end
        win_next = {w, win_reg[15:1]};
        t1 = v_reg[7] + big_sig1(v_reg[4])
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + round_k(rnd_reg) + w;
        t2 = big_sig0(v_reg[0])
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next[0] = t1 + t2;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2];
        v_next[4] = v_reg[3] + t1;
        v_next[5] = v_reg[4];
        v_next[6] = v_reg[5];
        v_next[7] = v_reg[6];
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    st_next = BK_ROUND;
                end
            end
            BK_ROUND:
            begin
                if (rnd_reg == 6'(ROUNDS - 1))
                begin
                    st_next = BK_ADD;
                end
            end
            BK_ADD:
            begin
                st_next = fin_reg ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT:
            begin
                if (dig.ready && idx_reg == 3'd7)
                begin
                    st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    assign dig.valid       = (st_reg == BK_EMIT);
    assign dig.digest_word = hash_reg[idx_reg];
    assign dig.word_index  = idx_reg;
    assign dig.last_word   = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= INIT_HASH;
            rnd_reg  <= '0;
            idx_reg  <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                BK_IDLE:
                begin
                    if (q_valid)
                    begin
                        rnd_reg <= '0;
                        fin_reg <= q_head.last_blk;
                    end
                end
                BK_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                BK_ADD:
                begin
                    for (int i = 0; i < DIG_WORDS; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    idx_reg <= '0;
                end
                BK_EMIT:
                begin
                    if (dig.ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            hash_reg <= INIT_HASH;
                        end
                    end
                end
                default:
                begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == BK_IDLE && q_valid)
        begin
            win_reg <= q_head.blk;
            v_reg   <= hash_reg;
        end
        else if (st_reg == BK_ROUND)
        begin
            win_reg <= win_next;
            v_reg   <= v_next;
        end
    end

    a_rounds_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_ROUND && rnd_reg == 6'(ROUNDS - 1)) |=> st_reg == BK_ADD)
        else $error("compression did not finish after last round");
    a_start_round0: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (st_reg == BK_ROUND && rnd_reg == '0))
        else $error("compression started off round zero");
    a_iv_restore: assert property (@(posedge clk) disable iff (!rst_n)
        (dig.valid && dig.ready && dig.last_word) |=> hash_reg == INIT_HASH)
        else $error("hash not restored after digest");

endmodule
